FILE: design/fpcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcr_pkg
// Types, constants and codes for the cubic root finder.
// ----------------------------------------------------------------------------
package fpcr_pkg;

    localparam int FRAC_BITS = 24;
    localparam int XW        = 32;
    localparam int RW        = 48;
    localparam int TOL_W     = 25;
    localparam int ITER_W    = 8;
    localparam int CFG_W     = 25;
    localparam int IDX_W     = 1;

    localparam logic [IDX_W-1:0] REG_TOLERANCE = 1'd0;
    localparam logic [IDX_W-1:0] REG_MAX_ITER  = 1'd1;

    localparam logic [TOL_W-1:0]  TOL_RESET  = 25'd168;
    localparam logic [ITER_W-1:0] ITER_RESET = 8'd100;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_NO_SIGN   = 2'd2;

    localparam logic signed [RW-1:0] RES_MAX = {1'b0, {(RW-1){1'b1}}};
    localparam logic signed [RW-1:0] RES_MIN = {1'b1, {(RW-1){1'b0}}};
    localparam logic [63:0] CUBE_LIM = 64'd1 << 50;
    localparam logic signed [RW-1:0] NINE = 48'sd9 <<< FRAC_BITS;

    typedef struct packed {
        logic signed [XW-1:0] a_start;
        logic signed [XW-1:0] b_start;
    } fpcr_in_t;

    typedef struct packed {
        logic signed [XW-1:0] root;
        logic [ITER_W-1:0]    iterations_used;
        logic signed [RW-1:0] residual;
        logic [1:0]           status;
    } fpcr_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FA_SQ,
        S_FA_CUBE,
        S_FB_SQ,
        S_FB_CUBE,
        S_CHECK,
        S_CH_MUL,
        S_CH_DIV,
        S_FC_SQ,
        S_FC_CUBE,
        S_DECIDE,
        S_OUT
    } fpcr_state_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_DONE
    } fpcr_mul_state_t;

endpackage

FILE: design/fpcr_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcr_stream_if
// Valid/ready channel carrying a packed payload.
// ----------------------------------------------------------------------------
interface fpcr_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/false_position_cubic_root_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// false_position_cubic_root_top
// Regula falsi root finder for x^3-4x-9 on a signed Q8.24 interval.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// in_ch    | in  | a_start, b_start (Q8.24)
// out_ch   | out | root, iterations_used, residual, status
// cfg      | in  | cfg_we, cfg_index, cfg_data
// One item at a time. Each cubic takes two passes of the shared multiplier;
// each iteration adds one product, a 128-step restoring division and one
// cubic; the product and division are skipped when f(a) equals f(b). An
// interval with no sign change goes to the result with no iteration.
// rst_n clears control and loads register defaults. in_ch.ready is low from
// transfer until the result transfers out; the result holds while stalled.
// ----------------------------------------------------------------------------
module false_position_cubic_root_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    fpcr_stream_if.sink                in_ch,
    fpcr_stream_if.source              out_ch,
    input  logic                       cfg_we,
    input  logic [fpcr_pkg::IDX_W-1:0] cfg_index,
    input  logic [fpcr_pkg::CFG_W-1:0] cfg_data
);
    import fpcr_pkg::*;

    fpcr_state_t state_reg, state_next;

    logic [TOL_W-1:0]  tol_reg;
    logic [ITER_W-1:0] max_iter_reg;

    logic signed [63:0] a_reg, b_reg, c_reg, x_reg;
    logic signed [RW-1:0] fa_reg, fb_reg, fc_reg;
    logic [63:0]  m_reg, sq_reg;
    logic [ITER_W-1:0] iter_reg, limit_reg;
    logic         neg_reg;
    logic [127:0] num_reg;
    logic [63:0]  rem_reg, q_reg, mden_reg;
    logic [6:0]   bit_reg;
    fpcr_out_t    res_reg;

    logic         mul_start, mul_done;
    logic [63:0]  mul_x, mul_y;
    logic [127:0] mul_p;

    fpcr_in_t in_data;
    logic signed [RW-1:0] f_val;
    logic signed [63:0] cube_s, tsum;
    logic [63:0] cube_m;
    logic [64:0] rem_sh;
    logic signed [63:0] d_val, den_val;
    logic signed [63:0] c_new;
    logic signed [RW-1:0] c_fa;
    logic fa_neg, fc_neg, fa_pos, fc_pos;
    logic [RW-1:0] fc_mag;

    assign in_data = fpcr_in_t'(in_ch.data);

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    fpcr_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .p     (mul_p)
    );

    // cubic finish from the second product
    always_comb
    begin
        if (mul_p[127:64+FRAC_BITS] != '0)
            cube_m = CUBE_LIM;
        else
        begin
            cube_m = mul_p[64+FRAC_BITS-1:FRAC_BITS];
            if (cube_m > CUBE_LIM)
                cube_m = CUBE_LIM;
        end
        cube_s = x_reg[63] ? -$signed(cube_m) : $signed(cube_m);
        tsum   = cube_s - (x_reg <<< 2) - 64'(NINE);
        if (tsum > 64'(RES_MAX))
            f_val = RES_MAX;
        else if (tsum < 64'(RES_MIN))
            f_val = RES_MIN;
        else
            f_val = tsum[RW-1:0];
    end

    always_comb
    begin
        d_val   = b_reg - a_reg;
        den_val = 64'(fa_reg) - 64'(fb_reg);
        rem_sh  = {rem_reg, num_reg[bit_reg]};
        c_new   = neg_reg ? a_reg - $signed({q_reg[62:0], rem_sh >= {1'b0, mden_reg}})
                          : a_reg + $signed({q_reg[62:0], rem_sh >= {1'b0, mden_reg}});
        c_fa    = fa_reg;
        fa_neg  = fa_reg[RW-1];
        fa_pos  = !fa_reg[RW-1] && fa_reg != '0;
        fc_neg  = fc_reg[RW-1];
        fc_pos  = !fc_reg[RW-1] && fc_reg != '0;
        fc_mag  = fc_reg[RW-1] ? RW'(-fc_reg) : RW'(fc_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_ch.valid) state_next = S_FA_SQ;
            S_FA_SQ:   if (mul_done) state_next = S_FA_CUBE;
            S_FA_CUBE: if (mul_done) state_next = S_FB_SQ;
            S_FB_SQ:   if (mul_done) state_next = S_FB_CUBE;
            S_FB_CUBE: if (mul_done) state_next = S_CHECK;
            S_CHECK:
            begin
                if ((fa_neg && !fb_reg[RW-1] && fb_reg != '0) ||
                    (fa_pos && fb_reg[RW-1]))
                    state_next = (den_val == 0) ? S_FC_SQ : S_CH_MUL;
                else
                    state_next = S_OUT;
            end
            S_CH_MUL:  if (mul_done) state_next = S_CH_DIV;
            S_CH_DIV:  if (bit_reg == 7'd0) state_next = S_FC_SQ;
            S_FC_SQ:   if (mul_done) state_next = S_FC_CUBE;
            S_FC_CUBE: if (mul_done) state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (fc_mag < RW'(tol_reg) || iter_reg == limit_reg)
                    state_next = S_OUT;
                else
                    state_next = (64'(fa_reg) - 64'(fb_reg) == 0) ? S_FC_SQ : S_CH_MUL;
            end
            S_OUT:     if (out_ch.ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready  = (state_reg == S_IDLE);
        out_ch.valid = (state_reg == S_OUT);
        out_ch.data  = res_reg;
        mul_start    = 1'b0;
        mul_x        = m_reg;
        mul_y        = m_reg;
        case (state_reg)
            S_FA_SQ, S_FB_SQ, S_FC_SQ:
            begin
                mul_start = 1'b1;
            end
            S_FA_CUBE, S_FB_CUBE, S_FC_CUBE:
            begin
                mul_start = 1'b1;
                mul_x     = sq_reg;
            end
            S_CH_MUL:
            begin
                mul_start = 1'b1;
                mul_x     = mag64(d_val);
                mul_y     = mag64(64'(c_fa));
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tol_reg      <= TOL_RESET;
            max_iter_reg <= ITER_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TOLERANCE: tol_reg      <= cfg_data[TOL_W-1:0];
                    REG_MAX_ITER:  max_iter_reg <= cfg_data[ITER_W-1:0];
                    default:       tol_reg      <= tol_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                a_reg     <= 64'(in_data.a_start);
                b_reg     <= 64'(in_data.b_start);
                x_reg     <= 64'(in_data.a_start);
                m_reg     <= mag64(64'(in_data.a_start));
                iter_reg  <= '0;
                limit_reg <= (max_iter_reg == '0) ? ITER_W'(1) : max_iter_reg;
            end
            S_FA_SQ, S_FB_SQ, S_FC_SQ:
                if (mul_done) sq_reg <= 64'(mul_p >> FRAC_BITS);
            S_FA_CUBE:
                if (mul_done)
                begin
                    fa_reg <= f_val;
                    x_reg  <= b_reg;
                    m_reg  <= mag64(b_reg);
                end
            S_FB_CUBE:
                if (mul_done) fb_reg <= f_val;
            S_CHECK:
            begin
                c_reg    <= a_reg;
                x_reg    <= a_reg;
                m_reg    <= mag64(a_reg);
                iter_reg <= iter_reg + ITER_W'(1);
                fc_reg   <= '0;
                neg_reg  <= ((d_val < 0) != fa_neg) != (den_val < 0);
                mden_reg <= mag64(den_val);
                res_reg  <= '{root: '0, iterations_used: '0, residual: '0,
                              status: ST_NO_SIGN};
            end
            S_CH_MUL:
                if (mul_done)
                begin
                    num_reg <= mul_p;
                    rem_reg <= '0;
                    q_reg   <= '0;
                    bit_reg <= 7'd127;
                end
            S_CH_DIV:
            begin
                if (rem_sh >= {1'b0, mden_reg})
                begin
                    rem_reg <= 64'(rem_sh - {1'b0, mden_reg});
                    q_reg   <= {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[63:0];
                    q_reg   <= {q_reg[62:0], 1'b0};
                end
                bit_reg <= bit_reg - 7'd1;
                if (bit_reg == 7'd0)
                begin
                    c_reg <= c_new;
                    x_reg <= c_new;
                    m_reg <= mag64(c_new);
                end
            end
            S_FC_CUBE:
                if (mul_done) fc_reg <= f_val;
            S_DECIDE:
            begin
                res_reg.root            <= c_reg[XW-1:0];
                res_reg.iterations_used <= iter_reg;
                res_reg.residual        <= fc_reg;
                res_reg.status          <= (fc_mag < RW'(tol_reg)) ? ST_CONVERGED : ST_LIMIT;
                if (!(fc_mag < RW'(tol_reg)) && iter_reg != limit_reg)
                begin
                    iter_reg <= iter_reg + ITER_W'(1);
                    if ((fa_neg && fc_pos) || (fa_pos && fc_neg))
                    begin
                        b_reg  <= c_reg;
                        fb_reg <= fc_reg;
                        neg_reg <= (((c_reg - a_reg) < 0) != fa_neg) !=
                                   ((64'(fa_reg) - 64'(fc_reg)) < 0);
                        mden_reg <= mag64(64'(fa_reg) - 64'(fc_reg));
                        if (64'(fa_reg) - 64'(fc_reg) == 0) c_reg <= a_reg;
                    end
                    else
                    begin
                        a_reg  <= c_reg;
                        fa_reg <= fc_reg;
                        neg_reg <= (((b_reg - c_reg) < 0) != fc_neg) !=
                                   ((64'(fc_reg) - 64'(fb_reg)) < 0);
                        mden_reg <= mag64(64'(fc_reg) - 64'(fb_reg));
                    end
                end
            end
            default:
            begin
                sq_reg <= sq_reg;
            end
        endcase
    end
endmodule

FILE: design/fpcr_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcr_mul
// Shared unsigned 64x64 multiplier, 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module fpcr_mul
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  x,
    input  logic [63:0]  y,
    output logic         done,
    output logic [127:0] p
);
    import fpcr_pkg::*;

    fpcr_mul_state_t state_reg, state_next;
    logic [1:0]   step_reg, step_next;
    logic [63:0]  x_reg, y_reg;
    logic [127:0] acc_reg, acc_next;
    logic [31:0]  xs, ys;
    logic [63:0]  pp_reg;
    logic [127:0] pp_shift;
    logic [1:0]   pp_step_reg;
    logic         pp_valid_reg;

    always_comb
    begin
        xs = step_reg[0] ? x_reg[63:32] : x_reg[31:0];
        ys = step_reg[1] ? y_reg[63:32] : y_reg[31:0];
    end

    always_comb
    begin
        case (pp_step_reg)
            2'd0:    pp_shift = {64'd0, pp_reg};
            2'd1:    pp_shift = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_shift = {32'd0, pp_reg, 32'd0};
            default: pp_shift = {pp_reg, 64'd0};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        case (state_reg)
            MUL_IDLE:
            begin
                if (start)
                begin
                    state_next = MUL_RUN;
                    step_next  = 2'd0;
                    acc_next   = '0;
                end
            end
            MUL_RUN:
            begin
                if (pp_valid_reg)
                    acc_next = acc_reg + pp_shift;
                if (step_reg == 2'd3 && pp_valid_reg && pp_step_reg == 2'd3)
                    state_next = MUL_DONE;
                else if (step_reg != 2'd3)
                    step_next = step_reg + 2'd1;
            end
            MUL_DONE:
                state_next = MUL_IDLE;
            default:
                state_next = MUL_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == MUL_DONE);
        p    = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= MUL_IDLE;
            step_reg     <= '0;
            pp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            pp_valid_reg <= (state_reg == MUL_RUN) && !(pp_valid_reg && pp_step_reg == 2'd3);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        pp_reg      <= xs * ys;
        pp_step_reg <= step_reg;
        if (state_reg == MUL_IDLE && start)
        begin
            x_reg <= x;
            y_reg <= y;
        end
    end
endmodule

FILE: design/fpcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcr_checker
// Port-level checks of the root finder; bound to the top level.
// ----------------------------------------------------------------------------
module fpcr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [89:0] out_data
);
    import fpcr_pkg::*;

    fpcr_out_t o;
    assign o = fpcr_out_t'(out_data);

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");

    a_nosign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && o.status == ST_NO_SIGN |-> o.iterations_used == 0 && o.root == 0)
        else $error("invalid interval with nonzero fields");

    a_iter: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (o.status == ST_CONVERGED || o.status == ST_LIMIT)
        |-> o.iterations_used != 0) else $error("zero iterations on success");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("accepted back to back");
endmodule

bind false_position_cubic_root_top fpcr_checker u_fpcr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
